// ===== hw/rtl/ordered_array_list_engine_macros.svh =====
// assertion macros for the array list engine
`ifndef ORDERED_ARRAY_LIST_ENGINE_MACROS_SVH
`define ORDERED_ARRAY_LIST_ENGINE_MACROS_SVH

// property must hold at every edge outside reset
`define OAL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent on the next edge
`define OAL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/oal_pkg.sv =====
// ----------------------------------------------------------------------------
// oal_pkg
// shared types and codes for the array list engine
// ----------------------------------------------------------------------------
package oal_pkg;

    localparam int unsigned DataW = 32;

    typedef enum logic [2:0] {
        REQ_READ      = 3'd0,
        REQ_INSERT    = 3'd1,
        REQ_OVERWRITE = 3'd2,
        REQ_REMOVE    = 3'd3,
        REQ_COUNT     = 3'd4,
        REQ_SORT      = 3'd5,
        REQ_BAD6      = 3'd6,
        REQ_BAD7      = 3'd7
    } req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_INS_RD,
        ST_INS_WR,
        ST_INS_PUT,
        ST_REM_RD,
        ST_REM_WR,
        ST_CNT_RD,
        ST_CNT_ACC,
        ST_SRT_RDI,
        ST_SRT_RDJ,
        ST_SRT_CMP,
        ST_SRT_SWP,
        ST_RD_WAIT,
        ST_RD_TAKE,
        ST_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load_req;     // latch request
        logic init_i;       // i = start index per op
        logic init_j;       // j = i + 1
        logic dec_i;
        logic inc_i;
        logic inc_j;
        logic rd_i;         // memory read at i
        logic rd_j;         // memory read at j
        logic rd_im1;       // read at i-1
        logic rd_ip1;       // read at i+1
        logic take_a;       // capture read data into a
        logic take_b;       // capture read data into b
        logic wr_i_rd;      // write last read data at i
        logic wr_i_val;     // write operand at i
        logic wr_i_b;       // write b at i
        logic wr_j_a;       // write a at j
        logic acc;          // count compare
        logic fill_inc;
        logic fill_dec;
        logic set_bad;
        logic set_data;     // result data = last read
        logic out_load;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        req_t op;
        logic pos_lt_fill;
        logic pos_le_fill;
        logic not_full;
        logic i_gt_pos;     // insert shift still running
        logic ip1_lt_fill;  // remove shift / outer sort loop
        logic i_lt_fill;
        logic j_lt_fill;
        logic a_gt_b;
        logic out_busy;
    } stat_t;

endpackage

// ===== hw/rtl/ordered_array_list_engine.sv =====
// ----------------------------------------------------------------------------
// ordered_array_list_engine
// array list of signed words with shifting insert and remove, count and sort
// ----------------------------------------------------------------------------
// One item is taken at a time. Read and overwrite need no loop; insert
// and remove read and then write each shifted entry, count reads and then
// compares each filled entry, and sort walks all pairs i<j with a read and
// a compare, plus an exchange step when the pair is out of order. The next
// item is accepted once the result has been handed to the output register.
module ordered_array_list_engine #(
    parameter int unsigned DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // req_type[2:0], position[10:3], operand_value[42:11]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // status[0], read_data[32:1], found[33], fill_count[38:34]
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata
);
    import oal_pkg::*;

    cmd_t  cmd;
    stat_t st;
    logic  idle;
    logic  in_fire;
    logic  o_status, o_found;
    logic signed [31:0] o_data;
    logic [4:0] o_fill;

    assign s_tready = idle;
    assign in_fire = s_tvalid && s_tready;
    assign m_tdata = {1'b0, o_fill, o_found, o_data, o_status};

    oal_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (in_fire),
        .st      (st),
        .cmd     (cmd),
        .idle    (idle)
    );

    oal_datapath #(.DEPTH(DEPTH)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .st            (st),
        .req_type      (s_tdata[2:0]),
        .position      (s_tdata[10:3]),
        .operand_value (s_tdata[42:11]),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_status    (o_status),
        .out_data      (o_data),
        .out_found     (o_found),
        .out_fill      (o_fill)
    );

endmodule

// ===== hw/rtl/oal_ctrl.sv =====
// ----------------------------------------------------------------------------
// oal_ctrl
// sequencer for the array list operations
// ----------------------------------------------------------------------------
module oal_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_fire,
    input  oal_pkg::stat_t st,
    output oal_pkg::cmd_t  cmd,
    output logic           idle
);
    import oal_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (in_fire) state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                unique case (st.op)
                    REQ_READ:      state_next = st.pos_lt_fill ? ST_RD_WAIT : ST_DONE;
                    REQ_INSERT:    state_next = (st.pos_le_fill && st.not_full) ?
                                                 ST_INS_RD : ST_DONE;
                    REQ_OVERWRITE: state_next = ST_DONE;
                    REQ_REMOVE:    state_next = st.pos_lt_fill ? ST_REM_RD : ST_DONE;
                    REQ_COUNT:     state_next = ST_CNT_RD;
                    REQ_SORT:      state_next = ST_SRT_RDI;
                    default:       state_next = ST_DONE;
                endcase
            end
            ST_INS_RD:  state_next = st.i_gt_pos ? ST_INS_WR : ST_INS_PUT;
            ST_INS_WR:  state_next = ST_INS_RD;
            ST_INS_PUT: state_next = ST_DONE;
            ST_REM_RD:  state_next = st.ip1_lt_fill ? ST_REM_WR : ST_DONE;
            ST_REM_WR:  state_next = ST_REM_RD;
            ST_CNT_RD:  state_next = st.i_lt_fill ? ST_CNT_ACC : ST_DONE;
            ST_CNT_ACC: state_next = ST_CNT_RD;
            ST_SRT_RDI: state_next = st.ip1_lt_fill ? ST_SRT_RDJ : ST_DONE;
            ST_SRT_RDJ: state_next = st.j_lt_fill ? ST_SRT_CMP : ST_SRT_RDI;
            ST_SRT_CMP: state_next = st.a_gt_b ? ST_SRT_SWP : ST_SRT_RDJ;
            ST_SRT_SWP: state_next = ST_SRT_RDJ;
            ST_RD_WAIT: state_next = ST_RD_TAKE;
            ST_RD_TAKE: state_next = ST_DONE;
            ST_DONE:    if (!st.out_busy) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        idle = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load_req = in_fire;
            end
            ST_DECIDE:
            begin
                cmd.init_i = 1'b1;
                unique case (st.op)
                    REQ_READ:
                    begin
                        cmd.rd_i = st.pos_lt_fill;
                        cmd.set_bad = !st.pos_lt_fill;
                    end
                    REQ_INSERT:    cmd.set_bad = !(st.pos_le_fill && st.not_full);
                    REQ_OVERWRITE:
                    begin
                        cmd.wr_i_val = st.pos_lt_fill;
                        cmd.set_bad = !st.pos_lt_fill;
                    end
                    REQ_REMOVE:    cmd.set_bad = !st.pos_lt_fill;
                    REQ_COUNT, REQ_SORT: ;
                    default:       cmd.set_bad = 1'b1;
                endcase
            end
            ST_INS_RD:
            begin
                // copy entry i-1 up to i while i > pos
                cmd.rd_im1 = st.i_gt_pos;
            end
            ST_INS_WR:
            begin
                cmd.wr_i_rd = 1'b1;
                cmd.dec_i = 1'b1;
            end
            ST_INS_PUT:
            begin
                cmd.wr_i_val = 1'b1;
                cmd.fill_inc = 1'b1;
            end
            ST_REM_RD:
            begin
                cmd.rd_ip1 = st.ip1_lt_fill;
                cmd.fill_dec = !st.ip1_lt_fill;
            end
            ST_REM_WR:
            begin
                cmd.wr_i_rd = 1'b1;
                cmd.inc_i = 1'b1;
            end
            ST_CNT_RD:  cmd.rd_i = st.i_lt_fill;
            ST_CNT_ACC:
            begin
                cmd.acc = 1'b1;
                cmd.inc_i = 1'b1;
            end
            ST_SRT_RDI:
            begin
                cmd.rd_i = 1'b1;
                cmd.init_j = 1'b1;
            end
            ST_SRT_RDJ:
            begin
                cmd.take_a = 1'b1;
                cmd.rd_j = st.j_lt_fill;
                cmd.inc_i = !st.j_lt_fill;
            end
            ST_SRT_CMP:
            begin
                cmd.take_b = 1'b1;
            end
            ST_SRT_SWP:
            begin
                // read data still holds the old entry j, now the new entry i
                cmd.wr_i_b = 1'b1;
                cmd.wr_j_a = 1'b1;
                cmd.inc_j = 1'b1;
            end
            ST_RD_WAIT: ;
            ST_RD_TAKE: cmd.set_data = 1'b1;
            ST_DONE:    cmd.out_load = !st.out_busy;
            default: ;
        endcase
        // in compare state a no-swap step also advances j and rereads entry i
        if (state_reg == ST_SRT_CMP && !st.a_gt_b)
        begin
            cmd.inc_j = 1'b1;
            cmd.rd_i = 1'b1;
        end
    end

endmodule

// ===== hw/rtl/oal_datapath.sv =====
// ----------------------------------------------------------------------------
// oal_datapath
// entry store, index counters, fill count and result register
// ----------------------------------------------------------------------------
module oal_datapath #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  oal_pkg::cmd_t             cmd,
    output oal_pkg::stat_t            st,
    input  logic [2:0]                req_type,
    input  logic [7:0]                position,
    input  logic signed [31:0]        operand_value,
    input  logic                      cfg_we,
    input  logic [4:0]                cfg_wdata,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      out_status,
    output logic signed [31:0]        out_data,
    output logic                      out_found,
    output logic [4:0]                out_fill
);
    import oal_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 2);
    localparam int unsigned IW = (CW > 9) ? CW : 9;

    logic signed [DataW-1:0] mem [DEPTH];
    logic signed [DataW-1:0] rd_reg;
    logic signed [DataW-1:0] a_reg, b_reg, val_reg, res_data_reg;
    req_t                    op_reg;
    logic [7:0]              pos_reg;
    logic [IW-1:0]           i_reg, j_reg;
    logic [CW-1:0]           fill_reg;
    logic [4:0]              cap_reg;
    logic                    bad_reg;
    logic [CW-1:0]           cnt_reg;
    logic [CW-1:0]           cap_eff;
    logic                    rd_en, wr_en;
    logic [IW-1:0]           rd_idx, wr_idx;
    logic signed [DataW-1:0] wr_data;
    logic [IW-1:0]           fill_x, pos_x;

    assign fill_x = IW'(fill_reg);
    assign pos_x  = IW'(pos_reg);
    assign cap_eff = (32'(cap_reg) > DEPTH) ? CW'(DEPTH) : CW'(cap_reg);

    always_comb
    begin
        rd_en = cmd.rd_i | cmd.rd_j | cmd.rd_im1 | cmd.rd_ip1;
        rd_idx = i_reg;
        if (cmd.rd_j)   rd_idx = j_reg;
        if (cmd.rd_im1) rd_idx = i_reg - IW'(1);
        if (cmd.rd_ip1) rd_idx = i_reg + IW'(1);
        // swap writes entry i here; entry j gets a through the pending write below
        wr_en = cmd.wr_i_rd | cmd.wr_i_val | cmd.wr_i_b | cmd.wr_j_a;
        wr_idx = i_reg;
        // read and overwrite act at the request position before i is loaded
        if (cmd.init_i)
        begin
            rd_idx = pos_x;
            wr_idx = pos_x;
        end
        wr_data = rd_reg;
        if (cmd.wr_i_val) wr_data = val_reg;
        if (cmd.wr_i_b)   wr_data = b_reg;
    end

    // swap: entry i takes b now; entry j gets a on the following edge
    logic                    pend_reg;
    logic [IW-1:0]           pend_idx_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en && !cmd.wr_j_a)
            mem[wr_idx[AW-1:0]] <= wr_data;
        else if (cmd.wr_j_a)
            mem[i_reg[AW-1:0]] <= b_reg;
        if (pend_reg)
            mem[pend_idx_reg[AW-1:0]] <= a_reg;
        if (rd_en)
            rd_reg <= mem[rd_idx[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 1'b0;
        else
            pend_reg <= cmd.wr_j_a;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_j_a)
            pend_idx_reg <= j_reg;
        if (cmd.load_req)
        begin
            op_reg  <= req_t'(req_type);
            pos_reg <= position;
            val_reg <= operand_value;
        end
        if (cmd.take_a) a_reg <= rd_reg;
        if (cmd.take_b) b_reg <= rd_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            cap_reg <= 5'd16;
            i_reg <= '0;
            j_reg <= '0;
            bad_reg <= 1'b0;
            cnt_reg <= '0;
            res_data_reg <= '0;
            out_valid <= 1'b0;
            out_status <= 1'b0;
            out_data <= '0;
            out_found <= 1'b0;
            out_fill <= '0;
        end
        else
        begin
            if (cfg_we) cap_reg <= cfg_wdata;
            if (cmd.load_req)
            begin
                bad_reg <= 1'b0;
                cnt_reg <= '0;
                res_data_reg <= '0;
            end
            if (cmd.init_i)
            begin
                if (op_reg == REQ_INSERT)
                    i_reg <= fill_x;
                else if (op_reg == REQ_COUNT || op_reg == REQ_SORT)
                    i_reg <= '0;
                else
                    i_reg <= pos_x;
            end
            if (cmd.dec_i) i_reg <= i_reg - IW'(1);
            if (cmd.inc_i) i_reg <= i_reg + IW'(1);
            if (cmd.init_j) j_reg <= i_reg + IW'(1);
            if (cmd.inc_j)  j_reg <= j_reg + IW'(1);
            if (cmd.set_bad) bad_reg <= 1'b1;
            if (cmd.acc && rd_reg == val_reg) cnt_reg <= cnt_reg + CW'(1);
            if (cmd.set_data) res_data_reg <= rd_reg;
            if (cmd.fill_inc) fill_reg <= fill_reg + CW'(1);
            if (cmd.fill_dec) fill_reg <= fill_reg - CW'(1);
            if (out_valid && out_ready) out_valid <= 1'b0;
            if (cmd.out_load)
            begin
                out_valid <= 1'b1;
                out_status <= bad_reg;
                out_fill <= 5'(fill_reg);
                if (op_reg == REQ_COUNT)
                begin
                    out_data <= DataW'(cnt_reg);
                    out_found <= (cnt_reg != '0);
                end
                else
                begin
                    out_data <= bad_reg ? '0 : res_data_reg;
                    out_found <= 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        st.op = op_reg;
        st.pos_lt_fill = pos_x < fill_x;
        st.pos_le_fill = pos_x <= fill_x;
        st.not_full = fill_reg < cap_eff;
        st.i_gt_pos = i_reg > pos_x;
        st.ip1_lt_fill = (i_reg + IW'(1)) < fill_x;
        st.i_lt_fill = i_reg < fill_x;
        st.j_lt_fill = j_reg < fill_x;
        st.a_gt_b = a_reg > rd_reg;
        st.out_busy = out_valid && !out_ready;
    end

    `include "ordered_array_list_engine_macros.svh"

    `OAL_ASSERT(a_fill_range, fill_reg <= CW'(DEPTH), "fill count beyond depth")
    `OAL_ASSERT(a_fill_excl, !(cmd.fill_inc && cmd.fill_dec), "fill inc and dec together")
    `OAL_ASSERT_NEXT(a_ins_grow, cmd.fill_inc, fill_reg == $past(fill_reg) + CW'(1),
        "insert did not grow fill")

endmodule
